/* rtl/bren_pkg.sv */
// Shared types and constants of the Brent root finder.
`timescale 1ns / 1ps

package bren_pkg;

    localparam int TOL_W = 47;
    localparam int LIMIT_W = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;
    localparam logic [TOL_W-1:0] TOL_RESET = 47'd1;
    localparam logic [LIMIT_W-1:0] STEP_MAX = 8'd255;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        ST_EVAL = 2'd0,
        ST_ROOT = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_GO,
        S_WAIT,
        S_DECIDE,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV,
        MD_DONE
    } t_md_state;

    typedef enum logic [2:0] {
        OP_IQI1,
        OP_IQI2,
        OP_IQI3,
        OP_IQI4,
        OP_IQI5,
        OP_IQI6,
        OP_SEC
    } t_op;

    typedef struct packed {
        logic ready;
        logic load_reject;
        logic load_root_end;
        logic load_start;
        logic load_answer;
        logic do_stop;
        logic md_go;
        logic md_store;
        logic decide;
        logic out_load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        logic kind;
        logic bad;
        logic end_root;
        logic searching;
        logic stop;
        logic use_iqi;
        logic md_done;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/bren_muldiv.sv */
// Serial multiply-divide unit: x*y/z truncated toward zero and saturated.
`timescale 1ns / 1ps

module bren_muldiv #(
    parameter int W = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic signed [W:0]   i_x,
    input  logic signed [W:0]   i_y,
    input  logic signed [W:0]   i_z,
    output logic                o_done,
    output logic signed [W-1:0] o_result
);

    localparam int M = W + 1;
    localparam int PW = 2 * M;
    localparam int CW = $clog2(M + 1);

    bren_pkg::t_md_state r_state, n_state;
    logic [PW-1:0] r_acc, r_mc;
    logic [M-1:0]  r_mp, r_d;
    logic [W-2:0]  r_q;
    logic [CW-1:0] r_cnt;
    logic          r_neg, r_sat;

    logic [M-1:0]  ux, uy, ud;
    logic [PW-1:0] lim;
    logic          prod_zero, sat_now, ge;
    logic signed [W-1:0] qx;

    assign ux = i_x[M-1] ? M'(-i_x) : M'(i_x);
    assign uy = i_y[M-1] ? M'(-i_y) : M'(i_y);
    assign ud = i_z[M-1] ? M'(-i_z) : M'(i_z);
    assign lim = PW'(r_d) << (W - 1);
    assign prod_zero = (r_acc == '0);
    assign sat_now = !prod_zero && ((r_d == '0) || (r_acc >= lim));
    assign ge = (r_acc >= r_mc);
    assign qx = signed'({1'b0, r_q});

    always_comb begin
        n_state = r_state;
        case (r_state)
            bren_pkg::MD_IDLE: if (i_go) n_state = bren_pkg::MD_MUL;
            bren_pkg::MD_MUL: if (r_cnt == CW'(M - 1)) n_state = bren_pkg::MD_CHK;
            bren_pkg::MD_CHK: n_state = (prod_zero || sat_now) ? bren_pkg::MD_DONE
                                                              : bren_pkg::MD_DIV;
            bren_pkg::MD_DIV: if (r_cnt == CW'(W - 2)) n_state = bren_pkg::MD_DONE;
            bren_pkg::MD_DONE: n_state = bren_pkg::MD_IDLE;
            default: n_state = bren_pkg::MD_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == bren_pkg::MD_DONE);
        if (r_sat) begin
            o_result = r_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            o_result = r_neg ? -qx : qx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bren_pkg::MD_IDLE;
            r_cnt <= '0;
            r_acc <= '0;
            r_mc <= '0;
            r_mp <= '0;
            r_d <= '0;
            r_q <= '0;
            r_neg <= 1'b0;
            r_sat <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                bren_pkg::MD_IDLE: begin
                    if (i_go) begin
                        r_acc <= '0;
                        r_mc <= PW'(ux);
                        r_mp <= uy;
                        r_d <= ud;
                        r_neg <= i_x[M-1] ^ i_y[M-1] ^ i_z[M-1];
                        r_cnt <= '0;
                    end
                end
                bren_pkg::MD_MUL: begin
                    if (r_mp[0]) r_acc <= r_acc + r_mc;
                    r_mc <= r_mc << 1;
                    r_mp <= r_mp >> 1;
                    r_cnt <= r_cnt + 1'b1;
                end
                bren_pkg::MD_CHK: begin
                    r_sat <= sat_now;
                    r_q <= '0;
                    r_mc <= PW'(r_d) << (W - 2);
                    r_cnt <= '0;
                end
                bren_pkg::MD_DIV: begin
                    if (ge) r_acc <= r_acc - r_mc;
                    r_q <= {r_q[W-3:0], ge};
                    r_mc <= r_mc >> 1;
                    r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/bren_datapath.sv */
// Datapath of the Brent root finder: search state, arithmetic and output word.
`timescale 1ns / 1ps

module bren_datapath #(
    parameter int W = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bren_pkg::t_cmd              i_cmd,
    output bren_pkg::t_dp_status        o_dp,
    input  logic                        i_valid,
    input  logic                        i_kind,
    input  logic signed [W-1:0]         i_left_point,
    input  logic signed [W-1:0]         i_right_point,
    input  logic signed [W-1:0]         i_left_value,
    input  logic signed [W-1:0]         i_right_value,
    input  logic signed [W-1:0]         i_probe_value,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [bren_pkg::TOL_W-1:0]  i_cfg_data,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic signed [W-1:0]         o_point
);

    localparam int X = (W + 3 > bren_pkg::TOL_W + 1) ? W + 3 : bren_pkg::TOL_W + 1;
    localparam int M = W + 1;
    localparam logic signed [X-1:0] VMAX_X = X'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [X-1:0] VMIN_X = ~VMAX_X;

    function automatic logic signed [X-1:0] f_abs(input logic signed [X-1:0] v);
        return v[X-1] ? -v : v;
    endfunction

    function automatic logic signed [W-1:0] f_sat(input logic signed [X-1:0] v);
        logic signed [X-1:0] c;
        c = (v > VMAX_X) ? VMAX_X : ((v < VMIN_X) ? VMIN_X : v);
        return W'(c);
    endfunction

    logic signed [W-1:0] r_ca, r_fa, r_cb, r_fb, r_cc, r_fc, r_cd, r_pend, r_tmp;
    logic signed [X-1:0] r_acc;
    logic signed [W-1:0] r_lp, r_rp, r_lv, r_rv, r_pv;
    logic                r_kind, r_bisect, r_searching;
    logic [bren_pkg::LIMIT_W-1:0] r_steps, r_limit;
    logic [bren_pkg::TOL_W-1:0]   r_tol;
    bren_pkg::t_status   r_res_status, r_out_status;
    logic signed [W-1:0] r_res_point, r_out_point;
    logic                r_out_valid;

    logic signed [X-1:0] xa, xfa, xb, xfb, xc, xfc, xd, xtol;
    logic signed [X-1:0] xlv, xrv;
    logic                start_swap, same_side, ans_swap;
    logic signed [W-1:0] na, nfa, nb, nfb;
    logic signed [M-1:0] md_x, md_y, md_z;
    logic                md_done;
    logic signed [W-1:0] md_res;
    logic signed [X-1:0] v3, lo0, lo, hi, last, xs, dba, half, sb;
    logic signed [W-1:0] s_interp, s_mid, s_new;
    logic                use_bis;

    assign xa = X'(r_ca);
    assign xfa = X'(r_fa);
    assign xb = X'(r_cb);
    assign xfb = X'(r_fb);
    assign xc = X'(r_cc);
    assign xfc = X'(r_fc);
    assign xd = X'(r_cd);
    assign xtol = signed'(X'({1'b0, r_tol}));
    assign xlv = X'(r_lv);
    assign xrv = X'(r_rv);

    assign start_swap = f_abs(xlv) < f_abs(xrv);
    assign same_side = (r_fa[W-1] == r_pv[W-1]);
    assign na = same_side ? r_pend : r_ca;
    assign nfa = same_side ? r_pv : r_fa;
    assign nb = same_side ? r_cb : r_pend;
    assign nfb = same_side ? r_fb : r_pv;
    assign ans_swap = f_abs(X'(nfa)) < f_abs(X'(nfb));

    always_comb begin
        o_dp.in_fire = i_valid && i_cmd.ready;
        o_dp.kind = r_kind;
        o_dp.bad = (r_lp > r_rp) ||
                   !(((r_lv[W-1] || r_lv == '0) && !r_rv[W-1]) ||
                     (!r_lv[W-1] && (r_rv[W-1] || r_rv == '0)));
        o_dp.end_root = (r_lv == '0) || (r_rv == '0);
        o_dp.searching = r_searching;
        o_dp.stop = (r_steps >= r_limit) || (r_fb == '0) || (f_abs(xb - xa) <= xtol);
        o_dp.use_iqi = (r_fa != r_fc) && (r_fb != r_fc);
        o_dp.md_done = md_done;
        o_dp.out_free = !r_out_valid || !i_stall;
    end

    always_comb begin
        case (i_cmd.op)
            bren_pkg::OP_IQI1: begin
                md_x = M'(r_fb); md_y = M'(r_fc); md_z = M'(xfa - xfb);
            end
            bren_pkg::OP_IQI2: begin
                md_x = M'(r_ca); md_y = M'(r_tmp); md_z = M'(xfa - xfc);
            end
            bren_pkg::OP_IQI3: begin
                md_x = M'(r_fa); md_y = M'(r_fc); md_z = M'(xfb - xfa);
            end
            bren_pkg::OP_IQI4: begin
                md_x = M'(r_cb); md_y = M'(r_tmp); md_z = M'(xfb - xfc);
            end
            bren_pkg::OP_IQI5: begin
                md_x = M'(r_fa); md_y = M'(r_fb); md_z = M'(xfc - xfa);
            end
            bren_pkg::OP_IQI6: begin
                md_x = M'(r_cc); md_y = M'(r_tmp); md_z = M'(xfc - xfb);
            end
            default: begin
                md_x = M'(r_fb); md_y = M'(xb - xa); md_z = M'(xfb - xfa);
            end
        endcase
    end

    bren_muldiv #(.W(W)) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (i_cmd.md_go),
        .i_x      (md_x),
        .i_y      (md_y),
        .i_z      (md_z),
        .o_done   (md_done),
        .o_result (md_res)
    );

    // Acceptance window for the interpolated point and the bisection fallback.
    always_comb begin
        s_interp = f_sat(r_acc);
        xs = X'(s_interp);
        v3 = xa + xa + xa + xb;
        lo0 = (v3 + (v3[X-1] ? X'(3) : X'(0))) >>> 2;
        lo = (lo0 > xb) ? xb : lo0;
        hi = (lo0 > xb) ? lo0 : xb;
        last = r_bisect ? f_abs(xb - xc) : f_abs(xc - xd);
        sb = f_abs(xs - xb);
        dba = xb - xa;
        half = (dba + (dba[X-1] ? X'(1) : X'(0))) >>> 1;
        s_mid = f_sat(xa + half);
        use_bis = !((lo < xs) && (xs < hi)) || ((sb + sb) >= last) || (last < xtol);
        s_new = use_bis ? s_mid : s_interp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca <= '0; r_fa <= '0; r_cb <= '0; r_fb <= '0;
            r_cc <= '0; r_fc <= '0; r_cd <= '0; r_pend <= '0;
            r_tmp <= '0; r_acc <= '0;
            r_lp <= '0; r_rp <= '0; r_lv <= '0; r_rv <= '0; r_pv <= '0;
            r_kind <= bren_pkg::KIND_START;
            r_bisect <= 1'b1;
            r_searching <= 1'b0;
            r_steps <= '0;
            r_limit <= bren_pkg::LIMIT_RESET;
            r_tol <= bren_pkg::TOL_RESET;
            r_res_status <= bren_pkg::ST_REJECT;
            r_res_point <= '0;
            r_out_status <= bren_pkg::ST_REJECT;
            r_out_point <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bren_pkg::CFG_TOLERANCE: r_tol <= i_cfg_data;
                    bren_pkg::CFG_LIMIT: r_limit <= i_cfg_data[bren_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (o_dp.in_fire) begin
                r_kind <= i_kind;
                r_lp <= i_left_point;
                r_rp <= i_right_point;
                r_lv <= i_left_value;
                r_rv <= i_right_value;
                r_pv <= i_probe_value;
            end
            if (i_cmd.load_reject) begin
                r_res_status <= bren_pkg::ST_REJECT;
                r_res_point <= '0;
            end
            if (i_cmd.load_root_end) begin
                r_res_status <= bren_pkg::ST_ROOT;
                r_res_point <= (r_lv == '0) ? r_lp : r_rp;
                r_searching <= 1'b0;
            end
            if (i_cmd.load_start) begin
                r_ca <= start_swap ? r_rp : r_lp;
                r_fa <= start_swap ? r_rv : r_lv;
                r_cb <= start_swap ? r_lp : r_rp;
                r_fb <= start_swap ? r_lv : r_rv;
                r_cc <= start_swap ? r_rp : r_lp;
                r_fc <= start_swap ? r_rv : r_lv;
                r_cd <= start_swap ? r_rp : r_lp;
                r_bisect <= 1'b1;
                r_steps <= '0;
                r_searching <= 1'b1;
            end
            if (i_cmd.load_answer) begin
                r_cd <= r_cc;
                r_cc <= r_cb;
                r_fc <= r_fb;
                r_ca <= ans_swap ? nb : na;
                r_fa <= ans_swap ? nfb : nfa;
                r_cb <= ans_swap ? na : nb;
                r_fb <= ans_swap ? nfa : nfb;
                if (r_steps != bren_pkg::STEP_MAX) r_steps <= r_steps + 1'b1;
            end
            if (i_cmd.do_stop) begin
                r_res_status <= bren_pkg::ST_ROOT;
                r_res_point <= r_cb;
                r_searching <= 1'b0;
            end
            if (i_cmd.md_store) begin
                case (i_cmd.op)
                    bren_pkg::OP_IQI1, bren_pkg::OP_IQI3, bren_pkg::OP_IQI5: r_tmp <= md_res;
                    bren_pkg::OP_IQI2: r_acc <= X'(md_res);
                    bren_pkg::OP_IQI4, bren_pkg::OP_IQI6: r_acc <= r_acc + X'(md_res);
                    default: r_acc <= xb - X'(md_res);
                endcase
            end
            if (i_cmd.decide) begin
                r_pend <= s_new;
                r_bisect <= use_bis;
                r_res_status <= bren_pkg::ST_EVAL;
                r_res_point <= s_new;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_out_status <= r_res_status;
                r_out_point <= r_res_point;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_status = r_out_status;
    assign o_point = r_out_point;

endmodule

/* rtl/bren_ctrl.sv */
// Sequencer of the Brent root finder: item intake, operation order and output.
`timescale 1ns / 1ps

module bren_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bren_pkg::t_dp_status i_dp,
    output bren_pkg::t_cmd       o_cmd
);

    bren_pkg::t_state r_state, n_state;
    bren_pkg::t_op    r_op, n_op;

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        case (r_state)
            bren_pkg::S_IDLE: if (i_dp.in_fire) n_state = bren_pkg::S_LOAD;
            bren_pkg::S_LOAD: begin
                if (i_dp.kind == bren_pkg::KIND_START) begin
                    n_state = (i_dp.bad || i_dp.end_root) ? bren_pkg::S_OUT
                                                          : bren_pkg::S_CHECK;
                end else begin
                    n_state = i_dp.searching ? bren_pkg::S_CHECK : bren_pkg::S_OUT;
                end
            end
            bren_pkg::S_CHECK: begin
                if (i_dp.stop) begin
                    n_state = bren_pkg::S_OUT;
                end else begin
                    n_state = bren_pkg::S_GO;
                    n_op = i_dp.use_iqi ? bren_pkg::OP_IQI1 : bren_pkg::OP_SEC;
                end
            end
            bren_pkg::S_GO: n_state = bren_pkg::S_WAIT;
            bren_pkg::S_WAIT: begin
                if (i_dp.md_done) begin
                    case (r_op)
                        bren_pkg::OP_IQI1: begin n_op = bren_pkg::OP_IQI2; n_state = bren_pkg::S_GO; end
                        bren_pkg::OP_IQI2: begin n_op = bren_pkg::OP_IQI3; n_state = bren_pkg::S_GO; end
                        bren_pkg::OP_IQI3: begin n_op = bren_pkg::OP_IQI4; n_state = bren_pkg::S_GO; end
                        bren_pkg::OP_IQI4: begin n_op = bren_pkg::OP_IQI5; n_state = bren_pkg::S_GO; end
                        bren_pkg::OP_IQI5: begin n_op = bren_pkg::OP_IQI6; n_state = bren_pkg::S_GO; end
                        default: n_state = bren_pkg::S_DECIDE;
                    endcase
                end
            end
            bren_pkg::S_DECIDE: n_state = bren_pkg::S_OUT;
            bren_pkg::S_OUT: if (i_dp.out_free) n_state = bren_pkg::S_IDLE;
            default: n_state = bren_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.op = r_op;
        case (r_state)
            bren_pkg::S_IDLE: o_cmd.ready = 1'b1;
            bren_pkg::S_LOAD: begin
                if (i_dp.kind == bren_pkg::KIND_START) begin
                    if (i_dp.bad) o_cmd.load_reject = 1'b1;
                    else if (i_dp.end_root) o_cmd.load_root_end = 1'b1;
                    else o_cmd.load_start = 1'b1;
                end else begin
                    if (i_dp.searching) o_cmd.load_answer = 1'b1;
                    else o_cmd.load_reject = 1'b1;
                end
            end
            bren_pkg::S_CHECK: o_cmd.do_stop = i_dp.stop;
            bren_pkg::S_GO: o_cmd.md_go = 1'b1;
            bren_pkg::S_WAIT: o_cmd.md_store = i_dp.md_done;
            bren_pkg::S_DECIDE: o_cmd.decide = 1'b1;
            bren_pkg::S_OUT: o_cmd.out_load = i_dp.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bren_pkg::S_IDLE;
            r_op <= bren_pkg::OP_SEC;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
        end
    end

endmodule

/* rtl/brent_root_finder_core.sv */
// Top level of the Brent-Dekker root finder in signed fixed point.
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_kind, i_*_point, i_*_value, i_probe_value
//  output   out        o_valid / i_stall   o_status, o_point
//  config   in         i_cfg_we            i_cfg_index, i_cfg_data
//
// A rejected word or a root at a bracket end goes straight from load to output.
// Each probe costs one or six passes through a serial multiply-divide unit (one
// bit per cycle in both the multiply and the divide).
// Reset clears all control state at once; no clearing pass is needed.
// A new word is taken whenever the sequencer is idle, even while a result waits
// under i_stall in the output register.
`timescale 1ns / 1ps

module brent_root_finder_core #(
    parameter int VALUE_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_kind,
    input  logic signed [VALUE_WIDTH-1:0] i_left_point,
    input  logic signed [VALUE_WIDTH-1:0] i_right_point,
    input  logic signed [VALUE_WIDTH-1:0] i_left_value,
    input  logic signed [VALUE_WIDTH-1:0] i_right_value,
    input  logic signed [VALUE_WIDTH-1:0] i_probe_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic signed [VALUE_WIDTH-1:0] o_point,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [bren_pkg::TOL_W-1:0]    i_cfg_data
);

    bren_pkg::t_cmd       cmd;
    bren_pkg::t_dp_status dp;

    assign o_stall = !cmd.ready;

    bren_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dp    (dp),
        .o_cmd   (cmd)
    );

    bren_datapath #(.W(VALUE_WIDTH)) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_dp          (dp),
        .i_valid       (i_valid),
        .i_kind        (i_kind),
        .i_left_point  (i_left_point),
        .i_right_point (i_right_point),
        .i_left_value  (i_left_value),
        .i_right_value (i_right_value),
        .i_probe_value (i_probe_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_point       (o_point)
    );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the Brent root finder core with a scoreboard class.
`timescale 1ns / 1ps

class brent_scoreboard;
    localparam longint VMAX = (64'sd1 <<< 47) - 1;
    localparam longint VMIN = -VMAX - 1;

    longint contra_pt, contra_val, best_pt, best_val;
    longint prev_pt, prev_val, older_pt, probe_pt;
    bit     bisected, searching;
    int     steps;
    longint tol;
    int     limit;
    bren_pkg::t_status exp_status[$];
    logic [47:0]       exp_point[$];
    int     errors;

    function new();
        contra_pt = 0; contra_val = 0; best_pt = 0; best_val = 0;
        prev_pt = 0; prev_val = 0; older_pt = 0; probe_pt = 0;
        bisected = 1; searching = 0; steps = 0;
        tol = 1; limit = 100; errors = 0;
    endfunction

    function void set_reg(bit idx, longint value);
        if (idx == bren_pkg::CFG_TOLERANCE) tol = value & ((64'sd1 <<< 47) - 1);
        else limit = int'(value & 64'hff);
    endfunction

    function longint clip(longint x);
        return x > VMAX ? VMAX : (x < VMIN ? VMIN : x);
    endfunction

    function longint absv(longint x);
        return x < 0 ? -x : x;
    endfunction

    // Exact x*y/z, truncated toward zero and saturated.
    function longint scale(longint x, longint y, longint z);
        logic [63:0]  ux, uy, ud, q;
        logic [127:0] p;
        bit           neg;
        ux = x < 0 ? -x : x;
        uy = y < 0 ? -y : y;
        ud = z < 0 ? -z : z;
        neg = ((x < 0) != (y < 0)) != (z < 0);
        if (ux == 0 || uy == 0) return 0;
        p = {64'd0, ux} * {64'd0, uy};
        if (ud == 0 || p[127:64] >= ud) q = '1;
        else q = 64'(p / {64'd0, ud});
        if (neg) return q > VMAX ? VMIN : -longint'(q);
        return q > VMAX ? VMAX : longint'(q);
    endfunction

    function void order_ends();
        longint t;
        if (absv(contra_val) < absv(best_val)) begin
            t = contra_pt; contra_pt = best_pt; best_pt = t;
            t = contra_val; contra_val = best_val; best_val = t;
        end
    endfunction

    function void push(bren_pkg::t_status st, longint pt);
        exp_status.push_back(st);
        exp_point.push_back(pt[47:0]);
    endfunction

    function void advance();
        longint a, fa, b, fb, c, fc, d, s, lo, hi, last, t;
        a = contra_pt; fa = contra_val; b = best_pt; fb = best_val;
        c = prev_pt; fc = prev_val; d = older_pt;
        if (steps >= limit || fb == 0 || absv(b - a) <= tol) begin
            searching = 0;
            push(bren_pkg::ST_ROOT, b);
            return;
        end
        if (fa != fc && fb != fc)
            s = clip(scale(a, scale(fb, fc, fa - fb), fa - fc)
                   + scale(b, scale(fa, fc, fb - fa), fb - fc)
                   + scale(c, scale(fa, fb, fc - fa), fc - fb));
        else
            s = clip(b - scale(fb, b - a, fb - fa));
        lo = (a + a + a + b) / 4;
        hi = b;
        if (lo > hi) begin
            t = lo; lo = hi; hi = t;
        end
        last = bisected ? absv(b - c) : absv(c - d);
        if (!(lo < s && s < hi) || 2 * absv(s - b) >= last || last < tol) begin
            s = clip(a + (b - a) / 2);
            bisected = 1;
        end else begin
            bisected = 0;
        end
        probe_pt = s;
        push(bren_pkg::ST_EVAL, s);
    endfunction

    function void note_word(bit kind, longint a, longint b, longint fa, longint fb,
                            longint fs);
        if (kind == bren_pkg::KIND_START) begin
            if (a > b || !((fa <= 0 && fb >= 0) || (fa >= 0 && fb <= 0))) begin
                push(bren_pkg::ST_REJECT, 0);
                return;
            end
            searching = 0;
            if (fa == 0 || fb == 0) begin
                push(bren_pkg::ST_ROOT, fa == 0 ? a : b);
                return;
            end
            contra_pt = a; contra_val = fa; best_pt = b; best_val = fb;
            order_ends();
            prev_pt = contra_pt; prev_val = contra_val; older_pt = contra_pt;
            bisected = 1; steps = 0; searching = 1;
            advance();
            return;
        end
        if (!searching) begin
            push(bren_pkg::ST_REJECT, 0);
            return;
        end
        older_pt = prev_pt;
        prev_pt = best_pt;
        prev_val = best_val;
        if ((contra_val < 0) == (fs < 0)) begin
            contra_pt = probe_pt; contra_val = fs;
        end else begin
            best_pt = probe_pt; best_val = fs;
        end
        order_ends();
        if (steps < 255) steps++;
        advance();
    endfunction

    function void check_word(logic [1:0] st, logic [47:0] pt);
        bren_pkg::t_status es;
        logic [47:0] ep;
        if (exp_status.size() == 0) begin
            $error("unexpected result word: status %0d point %h", st, pt);
            errors++;
            return;
        end
        es = exp_status.pop_front();
        ep = exp_point.pop_front();
        if (st !== es) begin
            $error("status: expected %0d, actual %0d", es, st);
            errors++;
        end
        if (pt !== ep) begin
            $error("point: expected %h, actual %h", ep, pt);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam longint VMAX = (64'sd1 <<< 47) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam longint TOL_MAX = (64'sd1 <<< 47) - 1;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int ITEMS = 1450;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_valid = 0;
    logic              o_stall;
    logic              i_kind = 0;
    logic signed [47:0] i_left_point = 0, i_right_point = 0;
    logic signed [47:0] i_left_value = 0, i_right_value = 0, i_probe_value = 0;
    logic              o_valid;
    logic              i_stall = 0;
    logic [1:0]        o_status;
    logic signed [47:0] o_point;
    logic              i_cfg_we = 0;
    logic              i_cfg_index = 0;
    logic [bren_pkg::TOL_W-1:0] i_cfg_data = 0;

    brent_root_finder_core u_top (.*);

    brent_scoreboard sb = new();
    int     cycles = 0;
    int     sent = 0;
    int     burst_left = 0;
    longint root, slope_dir;
    int     slope_shift;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("brent_root_finder_core verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_word(o_status, o_point);
    end

    // Receiver: mixed stall patterns plus one long hold-off.
    initial begin
        int mode, span;
        bit long_done;
        long_done = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 400);
            if (!long_done && cycles > 30000) begin
                long_done = 1;
                @(negedge i_clk) i_stall = 1;
                repeat (4000) @(negedge i_clk);
            end
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: i_stall = 0;
                    1: i_stall = ($urandom_range(0, 3) == 0);
                    2: i_stall = ($urandom_range(0, 1) == 0);
                    default: i_stall = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic longint rand_bits(int w);
        longint v;
        v = {$urandom, $urandom};
        return v >>> (64 - w);
    endfunction

    function automatic longint probe_fn(longint x);
        longint v;
        if ($urandom_range(0, 11) == 0) return rand_bits($urandom_range(2, 48));
        v = (x - root) >>> slope_shift;
        v = slope_dir > 0 ? v : -v;
        return v > VMAX ? VMAX : (v < VMIN ? VMIN : v);
    endfunction

    task automatic send(bit kind, longint a, longint b, longint fa, longint fb, longint fs);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 25);
            if ($urandom_range(0, 2) != 0) begin
                @(negedge i_clk) i_valid = 0;
                repeat ($urandom_range(1, 40)) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid = 1;
        i_kind = kind;
        i_left_point = a[47:0]; i_right_point = b[47:0];
        i_left_value = fa[47:0]; i_right_value = fb[47:0];
        i_probe_value = fs[47:0];
        do @(posedge i_clk); while (o_stall);
        sb.note_word(kind, a, b, fa, fb, fs);
        sent++;
        @(negedge i_clk) i_valid = 0;
    endtask

    task automatic send_answer(longint fs);
        send(bren_pkg::KIND_ANSWER, rand_bits(48), rand_bits(48), rand_bits(48),
             rand_bits(48), fs);
    endtask

    task automatic send_start(longint a, longint b, longint fa, longint fb);
        send(bren_pkg::KIND_START, a, b, fa, fb, rand_bits(48));
    endtask

    task automatic write_reg(bit idx, longint value);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_index = idx;
        i_cfg_data = value[bren_pkg::TOL_W-1:0];
        @(posedge i_clk);
        sb.set_reg(idx, value);
        @(negedge i_clk) i_cfg_we = 0;
    endtask

    task automatic drain();
        wait (sb.exp_status.size() == 0);
        repeat (900) @(posedge i_clk);
    endtask

    task automatic run_search(int span_bits);
        longint a, b, w;
        int n;
        w = rand_bits(span_bits);
        if (w < 0) w = -w;
        a = rand_bits(span_bits);
        b = a + w;
        if (b > VMAX) b = VMAX;
        root = a + (w > 0 ? longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % w : 0);
        slope_dir = $urandom_range(0, 1) ? 1 : -1;
        slope_shift = $urandom_range(0, 6);
        send_start(a, b, probe_fn(a), probe_fn(b));
        n = 0;
        while (sb.searching && n < 300 && $urandom_range(0, 40) != 0) begin
            send_answer(probe_fn(sb.probe_pt));
            n++;
        end
        if ($urandom_range(0, 9) == 0) send_answer(rand_bits(48));
    endtask

    task automatic random_phase(int count);
        int goal;
        goal = sent + count;
        while (sent < goal) begin
            if ($urandom_range(0, 9) == 0)
                send_start(rand_bits(48), rand_bits(48), rand_bits(48), rand_bits(48));
            else if ($urandom_range(0, 19) == 0)
                send_answer(rand_bits(48));
            else
                run_search($urandom_range(4, 47));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1;
        write_reg(bren_pkg::CFG_TOLERANCE, 1);
        write_reg(bren_pkg::CFG_LIMIT, 100);

        send_answer(5);
        send_start(10, -10, -1, 1);
        send_start(-10, 10, 3, 7);
        send_start(-10, 10, -3, -7);
        send_start(-1000, 2000, 0, 40);
        send_start(-1000, 2000, -40, 0);
        send_start(VMIN, VMAX, VMIN, VMAX);
        send_answer(VMAX);
        send_answer(VMIN);
        send_answer(0);
        send_start(VMIN, VMAX, VMAX, VMIN);
        send_answer(-1);
        send_start(-64'sd4294967296, 64'sd8589934592, -64'sd100, 64'sd200);
        send_answer(64'sd50);
        send_start(5, 5, -1, 1);
        root = 0; slope_dir = 1; slope_shift = 0;
        send_start(-100, 300, -100, 300);
        while (sb.searching) send_answer(probe_fn(sb.probe_pt));
        send_answer(7);
        drain();

        random_phase(300);
        drain();
        write_reg(bren_pkg::CFG_TOLERANCE, 0);
        write_reg(bren_pkg::CFG_LIMIT, 255);
        random_phase(300);
        drain();
        write_reg(bren_pkg::CFG_TOLERANCE, TOL_MAX);
        write_reg(bren_pkg::CFG_LIMIT, 1);
        random_phase(150);
        drain();
        write_reg(bren_pkg::CFG_TOLERANCE, 64'sd4096);
        write_reg(bren_pkg::CFG_LIMIT, 0);
        random_phase(100);
        drain();
        write_reg(bren_pkg::CFG_TOLERANCE, 64'sd65536);
        write_reg(bren_pkg::CFG_LIMIT, 7);
        random_phase(200);
        drain();
        write_reg(bren_pkg::CFG_TOLERANCE, 1);
        write_reg(bren_pkg::CFG_LIMIT, 40);
        random_phase(ITEMS - sent > 0 ? ITEMS - sent : 1);
        drain();

        if (sb.errors == 0)
            $display("brent_root_finder_core verification clean");
        else
            $display("brent_root_finder_core verification failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/bren_pkg.sv
rtl/bren_muldiv.sv
rtl/bren_datapath.sv
rtl/bren_ctrl.sv
rtl/brent_root_finder_core.sv
tb/sv/tb_top.sv
